@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file of the color converter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock while the block is out of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication checked while the block is out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// Condition checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, expr) \
    label: assert property (@(posedge clk) (expr)) \
        else $error("invariant check failed");

`endif

@@ sv/yrgb_pkg.sv @@
// ----------------------------------------------------------------------------
// yrgb_pkg
// Types and constants of the YCbCr 4:2:0 to RGB888 block converter.
// ----------------------------------------------------------------------------
package yrgb_pkg;

    localparam int SAMPLE_W = 8;
    localparam int PIXEL_W  = 24;
    localparam int PROD_W   = 17;   // constant times chroma magnitude, up to 587 * 128
    localparam int QUOT_W   = 8;    // largest quotient is floor(587 * 128 / 331) = 226
    localparam int OFF_W    = 10;   // signed channel offset
    localparam int SUM_W    = 11;   // signed luma plus offset

    // Coefficients as numerator over denominator.
    localparam int R_NUM   = 419;
    localparam int R_DEN   = 299;
    localparam int GCR_NUM = 299;
    localparam int GCR_DEN = 419;
    localparam int GCB_NUM = 114;
    localparam int GCB_DEN = 331;
    localparam int B_NUM   = 587;
    localparam int B_DEN   = 331;

    // Exact floor division of a PROD_W-bit value by a constant below 512:
    // multiply by ceil(2^SHIFT / den) and shift right by SHIFT.
    localparam int RECIP_SHIFT = PROD_W + 9;
    localparam int RECIP_W     = 18;
    localparam int MULT_W      = PROD_W + RECIP_W;
    localparam int R_RECIP   = ((2 ** RECIP_SHIFT) + R_DEN - 1) / R_DEN;
    localparam int GCR_RECIP = ((2 ** RECIP_SHIFT) + GCR_DEN - 1) / GCR_DEN;
    localparam int GCB_RECIP = ((2 ** RECIP_SHIFT) + GCB_DEN - 1) / GCB_DEN;
    localparam int B_RECIP   = ((2 ** RECIP_SHIFT) + B_DEN - 1) / B_DEN;

    localparam logic [SAMPLE_W-1:0] CHROMA_BIAS = 8'd128;
    localparam logic [SAMPLE_W-1:0] CHANNEL_MAX = 8'd255;

    // Quotient magnitudes and chroma signs leaving the offset unit.
    typedef struct packed {
        logic              cr_neg;
        logic              cb_neg;
        logic [QUOT_W-1:0] q_r;
        logic [QUOT_W-1:0] q_gcr;
        logic [QUOT_W-1:0] q_gcb;
        logic [QUOT_W-1:0] q_b;
    } quot_t;

    // Signed channel offsets shared by the four pixel lanes.
    typedef struct packed {
        logic signed [OFF_W-1:0] r;
        logic signed [OFF_W-1:0] g;
        logic signed [OFF_W-1:0] b;
    } chan_off_t;

endpackage

@@ sv/yrgb_offset.sv @@
// ----------------------------------------------------------------------------
// yrgb_offset
// Two-stage chroma offset unit: constant products, then reciprocal division.
// ----------------------------------------------------------------------------
module yrgb_offset
(
    input  logic                          clk,
    input  logic                          load_prod,
    input  logic                          load_quot,
    input  logic [yrgb_pkg::SAMPLE_W-1:0] chroma_red,
    input  logic [yrgb_pkg::SAMPLE_W-1:0] chroma_blue,
    output yrgb_pkg::quot_t               quot
);

    logic [yrgb_pkg::SAMPLE_W-1:0] cr_mag;
    logic [yrgb_pkg::SAMPLE_W-1:0] cb_mag;
    logic                          cr_neg_next;
    logic                          cb_neg_next;

    logic [yrgb_pkg::PROD_W-1:0] p_r_reg, p_r_next;
    logic [yrgb_pkg::PROD_W-1:0] p_gcr_reg, p_gcr_next;
    logic [yrgb_pkg::PROD_W-1:0] p_gcb_reg, p_gcb_next;
    logic [yrgb_pkg::PROD_W-1:0] p_b_reg, p_b_next;
    logic                        cr_neg_reg, cb_neg_reg;

    yrgb_pkg::quot_t quot_reg, quot_next;

    // The sign of C - 128 is the inverted top bit; the magnitude is at most 128.
    always_comb
    begin
        cr_neg_next = ~chroma_red[yrgb_pkg::SAMPLE_W-1];
        cb_neg_next = ~chroma_blue[yrgb_pkg::SAMPLE_W-1];
        cr_mag = cr_neg_next ? (yrgb_pkg::CHROMA_BIAS - chroma_red)
                             : (chroma_red - yrgb_pkg::CHROMA_BIAS);
        cb_mag = cb_neg_next ? (yrgb_pkg::CHROMA_BIAS - chroma_blue)
                             : (chroma_blue - yrgb_pkg::CHROMA_BIAS);

        p_r_next   = yrgb_pkg::PROD_W'(yrgb_pkg::R_NUM) * yrgb_pkg::PROD_W'(cr_mag);
        p_gcr_next = yrgb_pkg::PROD_W'(yrgb_pkg::GCR_NUM) * yrgb_pkg::PROD_W'(cr_mag);
        p_gcb_next = yrgb_pkg::PROD_W'(yrgb_pkg::GCB_NUM) * yrgb_pkg::PROD_W'(cb_mag);
        p_b_next   = yrgb_pkg::PROD_W'(yrgb_pkg::B_NUM) * yrgb_pkg::PROD_W'(cb_mag);
    end

    always_comb
    begin
        quot_next.cr_neg = cr_neg_reg;
        quot_next.cb_neg = cb_neg_reg;
        quot_next.q_r    = yrgb_pkg::QUOT_W'(
            (yrgb_pkg::MULT_W'(p_r_reg) * yrgb_pkg::MULT_W'(yrgb_pkg::R_RECIP))
            >> yrgb_pkg::RECIP_SHIFT);
        quot_next.q_gcr  = yrgb_pkg::QUOT_W'(
            (yrgb_pkg::MULT_W'(p_gcr_reg) * yrgb_pkg::MULT_W'(yrgb_pkg::GCR_RECIP))
            >> yrgb_pkg::RECIP_SHIFT);
        quot_next.q_gcb  = yrgb_pkg::QUOT_W'(
            (yrgb_pkg::MULT_W'(p_gcb_reg) * yrgb_pkg::MULT_W'(yrgb_pkg::GCB_RECIP))
            >> yrgb_pkg::RECIP_SHIFT);
        quot_next.q_b    = yrgb_pkg::QUOT_W'(
            (yrgb_pkg::MULT_W'(p_b_reg) * yrgb_pkg::MULT_W'(yrgb_pkg::B_RECIP))
            >> yrgb_pkg::RECIP_SHIFT);
    end

    // Payload only; the valid bits live in the top level.
    always_ff @(posedge clk)
    begin
        if (load_prod)
        begin
            p_r_reg    <= p_r_next;
            p_gcr_reg  <= p_gcr_next;
            p_gcb_reg  <= p_gcb_next;
            p_b_reg    <= p_b_next;
            cr_neg_reg <= cr_neg_next;
            cb_neg_reg <= cb_neg_next;
        end
        if (load_quot)
        begin
            quot_reg <= quot_next;
        end
    end

    assign quot = quot_reg;

endmodule

@@ sv/yrgb_lane.sv @@
// ----------------------------------------------------------------------------
// yrgb_lane
// One pixel lane: adds the channel offsets to a luma sample, clamps, packs.
// ----------------------------------------------------------------------------
module yrgb_lane
(
    input  logic [yrgb_pkg::SAMPLE_W-1:0] luma,
    input  yrgb_pkg::chan_off_t           offs,
    output logic [yrgb_pkg::PIXEL_W-1:0]  pixel
);

    function automatic logic [yrgb_pkg::SAMPLE_W-1:0] clamp_add(
        input logic [yrgb_pkg::SAMPLE_W-1:0] y,
        input logic signed [yrgb_pkg::OFF_W-1:0] off
    );
        logic signed [yrgb_pkg::SUM_W-1:0] sum;
        logic [yrgb_pkg::SAMPLE_W-1:0]     res;
        sum = $signed({3'b000, y}) + yrgb_pkg::SUM_W'(off);
        if (sum[yrgb_pkg::SUM_W-1])
        begin
            res = '0;
        end
        else if (sum[yrgb_pkg::SUM_W-2:yrgb_pkg::SAMPLE_W] != '0)
        begin
            res = yrgb_pkg::CHANNEL_MAX;
        end
        else
        begin
            res = sum[yrgb_pkg::SAMPLE_W-1:0];
        end
        return res;
    endfunction

    assign pixel = {clamp_add(luma, offs.r), clamp_add(luma, offs.g),
                    clamp_add(luma, offs.b)};

endmodule

@@ sv/yuv420_to_rgb_block.sv @@
// ----------------------------------------------------------------------------
// yuv420_to_rgb_block
// Converts one 2x2 luma block with shared Cr/Cb into four packed RGB pixels.
// ----------------------------------------------------------------------------
//  Channel   Direction  Signals                 Payload
//  s_axis    in         tvalid, tready, tdata   Cr, Cb and four luma samples
//  m_axis    out        tvalid, tready, tdata   four 24-bit RGB pixels
//
//  One block enters per clock while s_tready is high; it passes three register
//  stages (product, reciprocal multiply, lanes and merge) and can leave once
//  it reaches the last. The pipeline advances stage by stage, so bubbles
//  collapse under stall and input is still taken while a finished
//  transaction waits at the output, until all three stages are full.
//  rst_n clears the stage valid bits asynchronously; data registers hold.
// ----------------------------------------------------------------------------
module yuv420_to_rgb_block
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // chroma_red, chroma_blue, luma_top_left, luma_top_right,
    // luma_bottom_left, luma_bottom_right (8 bits each)
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // pixel_top_left, pixel_top_right, pixel_bottom_left,
    // pixel_bottom_right (24 bits each)
    output logic [95:0] m_tdata
);

    localparam int LANES = 4;
    localparam int SW    = yrgb_pkg::SAMPLE_W;
    localparam int PW    = yrgb_pkg::PIXEL_W;

    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;
    logic ready1, ready2, ready3;
    logic load1, load2;

    logic [SW-1:0] luma1_reg [LANES];
    logic [SW-1:0] luma2_reg [LANES];
    logic [PW-1:0] pix_next  [LANES];
    logic [LANES*PW-1:0] out_reg, out_next;

    yrgb_pkg::quot_t     quot;
    yrgb_pkg::chan_off_t offs;
    logic signed [yrgb_pkg::OFF_W-1:0] q_r, q_gcr, q_gcb, q_b;

    // Each stage moves on when the next one is empty or moving itself.
    assign ready3 = !v3_reg || m_tready;
    assign ready2 = !v2_reg || ready3;
    assign ready1 = !v1_reg || ready2;
    assign load1  = s_tvalid && ready1;
    assign load2  = v1_reg && ready2;

    assign v1_next = ready1 ? s_tvalid : v1_reg;
    assign v2_next = ready2 ? v1_reg   : v2_reg;
    assign v3_next = ready3 ? v2_reg   : v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    yrgb_offset u_offset
    (
        .clk         (clk),
        .load_prod   (load1),
        .load_quot   (load2),
        .chroma_red  (s_tdata[SW-1:0]),
        .chroma_blue (s_tdata[2*SW-1:SW]),
        .quot        (quot)
    );

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (load1)
            begin
                luma1_reg[i] <= s_tdata[(i+2)*SW +: SW];
            end
            if (load2)
            begin
                luma2_reg[i] <= luma1_reg[i];
            end
        end
    end

    // Turn magnitudes back into signed offsets; green carries two negated terms.
    always_comb
    begin
        q_r   = yrgb_pkg::OFF_W'(quot.q_r);
        q_gcr = yrgb_pkg::OFF_W'(quot.q_gcr);
        q_gcb = yrgb_pkg::OFF_W'(quot.q_gcb);
        q_b   = yrgb_pkg::OFF_W'(quot.q_b);
        offs.r = quot.cr_neg ? -q_r : q_r;
        offs.g = (quot.cr_neg ? q_gcr : -q_gcr) + (quot.cb_neg ? q_gcb : -q_gcb);
        offs.b = quot.cb_neg ? -q_b : q_b;
    end

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        yrgb_lane u_lane
        (
            .luma  (luma2_reg[g]),
            .offs  (offs),
            .pixel (pix_next[g])
        );
    end

    // Merge the four lanes into the output register.
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            out_next[i*PW +: PW] = pix_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (v2_reg && ready3)
        begin
            out_reg <= out_next;
        end
    end

    assign s_tready = ready1;
    assign m_tvalid = v3_reg;
    assign m_tdata  = out_reg;

endmodule

@@ sv/yrgb_checker.sv @@
// ----------------------------------------------------------------------------
// yrgb_checker
// Port-level checks of the color converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module yrgb_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata
);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `ASSERT_NEXT(a_out_stable, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata))
    // The input only stalls when the output holds an untaken transaction.
    `ASSERT_IMPLIES(a_stall_cause, clk, rst_n, !s_tready, m_tvalid && !m_tready)
    // Before the first reset edge the valid bit is still unknown.
    `ASSERT_ALWAYS(a_reset_empty, clk, rst_n || (m_tvalid !== 1'b1))

endmodule

bind yuv420_to_rgb_block yrgb_checker u_yrgb_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 2x2 YCbCr to RGB888 block converter. A local
// color-conversion model predicts the four pixels of every accepted block,
// and each output transaction is compared pixel by pixel against the oldest
// prediction. Stimulus is a directed corner set followed by random blocks
// sent in bursts, while the output side applies its own backpressure.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int RANDOM_BLOCKS = 630;
    localparam int DRAIN_EVERY   = 150;
    localparam int TAIL_CYCLES   = 12;

    // Input block, first field in the lowest bits.
    typedef struct packed {
        logic [yrgb_pkg::SAMPLE_W-1:0] luma_bottom_right;
        logic [yrgb_pkg::SAMPLE_W-1:0] luma_bottom_left;
        logic [yrgb_pkg::SAMPLE_W-1:0] luma_top_right;
        logic [yrgb_pkg::SAMPLE_W-1:0] luma_top_left;
        logic [yrgb_pkg::SAMPLE_W-1:0] chroma_blue;
        logic [yrgb_pkg::SAMPLE_W-1:0] chroma_red;
    } ycc_block_t;

    // Output quad, top left pixel in the lowest bits.
    typedef struct packed {
        logic [yrgb_pkg::PIXEL_W-1:0] pixel_bottom_right;
        logic [yrgb_pkg::PIXEL_W-1:0] pixel_bottom_left;
        logic [yrgb_pkg::PIXEL_W-1:0] pixel_top_right;
        logic [yrgb_pkg::PIXEL_W-1:0] pixel_top_left;
    } rgb_quad_t;

    class pixel_scoreboard;
        rgb_quad_t expected_quads[$];
        int        mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        function logic [7:0] saturate8(int v);
            if (v < 0)
                return 8'd0;
            if (v > 255)
                return 8'd255;
            return v[7:0];
        endfunction

        function logic [yrgb_pkg::PIXEL_W-1:0] shade(logic [yrgb_pkg::SAMPLE_W-1:0] luma,
                                                     int off_r, int off_g, int off_b);
            int y;
            y = int'(luma);
            return {saturate8(y + off_r), saturate8(y + off_g), saturate8(y + off_b)};
        endfunction

        // Signed int division truncates toward zero, as the offsets require.
        function rgb_quad_t convert_block(ycc_block_t blk);
            int        d_cr;
            int        d_cb;
            int        off_r;
            int        off_g;
            int        off_b;
            rgb_quad_t quad;
            d_cr  = int'(blk.chroma_red) - int'(yrgb_pkg::CHROMA_BIAS);
            d_cb  = int'(blk.chroma_blue) - int'(yrgb_pkg::CHROMA_BIAS);
            off_r = (yrgb_pkg::R_NUM * d_cr) / yrgb_pkg::R_DEN;
            off_g = (-yrgb_pkg::GCR_NUM * d_cr) / yrgb_pkg::GCR_DEN
                  + (-yrgb_pkg::GCB_NUM * d_cb) / yrgb_pkg::GCB_DEN;
            off_b = (yrgb_pkg::B_NUM * d_cb) / yrgb_pkg::B_DEN;
            quad.pixel_top_left     = shade(blk.luma_top_left, off_r, off_g, off_b);
            quad.pixel_top_right    = shade(blk.luma_top_right, off_r, off_g, off_b);
            quad.pixel_bottom_left  = shade(blk.luma_bottom_left, off_r, off_g, off_b);
            quad.pixel_bottom_right = shade(blk.luma_bottom_right, off_r, off_g, off_b);
            return quad;
        endfunction

        function void note_block(ycc_block_t blk);
            expected_quads.push_back(convert_block(blk));
        endfunction

        function int pending();
            return expected_quads.size();
        endfunction

        task report(string msg);
            mismatch_count++;
            $display("[%0t] MISMATCH %s", $time, msg);
        endtask

        task check_quad(logic [4*yrgb_pkg::PIXEL_W-1:0] got);
            rgb_quad_t                    want;
            logic [yrgb_pkg::PIXEL_W-1:0] got_px;
            logic [yrgb_pkg::PIXEL_W-1:0] want_px;
            string lane_name [4] = '{"top_left", "top_right", "bottom_left", "bottom_right"};
            if (expected_quads.size() == 0)
            begin
                report($sformatf("output transaction %h with nothing expected", got));
                return;
            end
            want = expected_quads.pop_front();
            for (int k = 0; k < 4; k++)
            begin
                got_px  = got[k*yrgb_pkg::PIXEL_W +: yrgb_pkg::PIXEL_W];
                want_px = want[k*yrgb_pkg::PIXEL_W +: yrgb_pkg::PIXEL_W];
                if (got_px !== want_px)
                    report($sformatf("pixel_%s got %h expected %h",
                                     lane_name[k], got_px, want_px));
            end
        endtask
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;

    pixel_scoreboard sb = new();

    int stall_mode = 0;
    int stall_span = 0;

    yuv420_to_rgb_block uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Both sides in one process so an input is always noted before any
    // output that could depend on it in the same cycle.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_block(ycc_block_t'(s_tdata));
        if (rst_n && m_tvalid && m_tready)
            sb.check_quad(m_tdata);
    end

    // Output backpressure: a random stall mode sets how often m_tready is high and is redrawn when its span runs out.
    always @(posedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_span <= $urandom_range(20, 200);
        end
        else
        begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= ($urandom_range(0, 1) != 0);
            default: m_tready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    function automatic ycc_block_t make_block(int cr, int cb, int tl, int tr,
                                              int bl, int br);
        ycc_block_t blk;
        blk.chroma_red        = cr[7:0];
        blk.chroma_blue       = cb[7:0];
        blk.luma_top_left     = tl[7:0];
        blk.luma_top_right    = tr[7:0];
        blk.luma_bottom_left  = bl[7:0];
        blk.luma_bottom_right = br[7:0];
        return blk;
    endfunction

    function automatic int edge_chroma();
        int picks [7] = '{0, 1, 127, 128, 129, 254, 255};
        return picks[$urandom_range(0, 6)];
    endfunction

    function automatic int edge_luma();
        return ($urandom_range(0, 1) != 0) ? $urandom_range(0, 15) : $urandom_range(240, 255);
    endfunction

    // Half uniform blocks, the rest weighted toward chroma or luma
    // extremes so that every channel hits both clamps often.
    function automatic ycc_block_t random_block();
        case ($urandom_range(0, 3)) inside
            0, 1:
                return make_block($urandom_range(0, 255), $urandom_range(0, 255),
                                  $urandom_range(0, 255), $urandom_range(0, 255),
                                  $urandom_range(0, 255), $urandom_range(0, 255));
            2:
                return make_block(edge_chroma(), edge_chroma(),
                                  $urandom_range(0, 255), $urandom_range(0, 255),
                                  $urandom_range(0, 255), $urandom_range(0, 255));
            default:
                return make_block($urandom_range(0, 255), $urandom_range(0, 255),
                                  edge_luma(), edge_luma(), edge_luma(), edge_luma());
        endcase
    endfunction

    task automatic send_block(input ycc_block_t blk);
        s_tvalid <= 1'b1;
        s_tdata  <= blk;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic hold_off(input int cycles);
        if (cycles > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int sent;
        int burst;
        int next_drain;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes, neutral chroma, each clamp on each channel, and the
        // smallest nonzero chroma deltas where truncation matters most.
        send_block(make_block(0, 0, 0, 0, 0, 0));
        send_block(make_block(255, 255, 255, 255, 255, 255));
        send_block(make_block(128, 128, 0, 255, 1, 254));
        send_block(make_block(128, 128, 17, 100, 200, 128));
        send_block(make_block(255, 128, 200, 255, 0, 60));
        send_block(make_block(0, 128, 0, 40, 100, 255));
        hold_off(3);
        send_block(make_block(128, 255, 0, 30, 230, 255));
        send_block(make_block(128, 0, 0, 30, 230, 255));
        send_block(make_block(0, 0, 255, 128, 0, 64));
        send_block(make_block(255, 255, 0, 128, 255, 64));
        send_block(make_block(127, 129, 100, 100, 100, 100));
        send_block(make_block(129, 127, 100, 100, 100, 100));
        send_block(make_block(170, 85, 170, 85, 170, 85));
        send_block(make_block(85, 170, 85, 170, 85, 170));
        hold_off(1);
        send_block(make_block(1, 254, 2, 253, 4, 251));
        send_block(make_block(254, 1, 8, 247, 16, 239));
        send_block(make_block(32, 224, 64, 191, 128, 127));
        send_block(make_block(0, 255, 128, 128, 128, 128));
        send_block(make_block(255, 0, 128, 128, 128, 128));
        wait_for_drain();

        sent       = 0;
        next_drain = DRAIN_EVERY;
        while (sent < RANDOM_BLOCKS)
        begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < RANDOM_BLOCKS; k++)
            begin
                send_block(random_block());
                sent++;
            end
            if (sent >= next_drain)
            begin
                next_drain += DRAIN_EVERY;
                wait_for_drain();
            end
            else if ($urandom_range(0, 3) != 0)
            begin
                hold_off($urandom_range(1, 6));
            end
        end

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d output transactions never arrived", sb.pending()));
        if (sb.mismatch_count == 0)
            $display("yuv420_to_rgb_block verification clean");
        else
            $display("yuv420_to_rgb_block verification failed");
        $finish;
    end

    initial
    begin
        #200000;
        $display("yuv420_to_rgb_block verification failed");
        $finish;
    end

endmodule
